// ===== sv/fir_rb_pkg.sv =====
// fir_rb_pkg: shared widths, mode codes, controller states and the
// command/status bundles between the fir ring-buffer controller and datapath.
// No dependencies.
package fir_rb_pkg;

  localparam int unsigned MAX_TAPS_DEF = 32;
  localparam int unsigned TAPS_RST     = 32;

  localparam int unsigned MODE_W     = 1;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned COEF_IDX_W = 5;
  localparam int unsigned TAPS_W     = 6;
  localparam int unsigned PROD_W     = 32;
  localparam int unsigned ACC_W      = 40;
  localparam int unsigned FRAC_W     = 15;

  localparam logic [MODE_W-1:0] MODE_SAMPLE = 1'b0;
  localparam logic [MODE_W-1:0] MODE_COEF   = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN
  } fir_state_t;

  typedef struct packed {
    logic take_sample;
    logic take_coef;
    logic issue;
    logic load_out;
  } fir_cmd_t;

  typedef struct packed {
    logic last_tap;
    logic pipe_busy;
    logic out_free;
  } fir_stat_t;

endpackage

// ===== sv/fir_rb_if.sv =====
// fir_rb channel interfaces: input item, result item and tap-count write port.
// Depends on fir_rb_pkg for field widths.
interface fir_rb_in_if;
  import fir_rb_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [MODE_W-1:0]          mode;
  logic signed [SAMPLE_W-1:0] sample_in;
  logic [COEF_IDX_W-1:0]      coef_index;
  logic signed [SAMPLE_W-1:0] coef_value;
  modport source (output valid, mode, sample_in, coef_index, coef_value, input ready);
  modport sink   (input valid, mode, sample_in, coef_index, coef_value, output ready);
endinterface

interface fir_rb_out_if;
  import fir_rb_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] filtered;
  logic                       saturated;
  modport source (output valid, filtered, saturated, input ready);
  modport sink   (input valid, filtered, saturated, output ready);
endinterface

interface fir_rb_cfg_if;
  import fir_rb_pkg::*;
  logic              valid;
  logic              ready;
  logic [TAPS_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== sv/fir_rb_ctrl.sv =====
// fir_rb_ctrl: state machine sequencing one sample through the shared MAC.
// Depends on fir_rb_pkg for states and the command/status structs.
module fir_rb_ctrl (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic [fir_rb_pkg::MODE_W-1:0]    in_mode,
  output logic                             in_ready,
  input  fir_rb_pkg::fir_stat_t            stat,
  output fir_rb_pkg::fir_cmd_t             cmd
);
  import fir_rb_pkg::*;

  fir_state_t state;
  fir_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_mode == MODE_COEF) begin
            cmd.take_coef = 1'b1;
          end else begin
            cmd.take_sample = 1'b1;
            state_next      = ST_ISSUE;
          end
        end
      end
      ST_ISSUE: begin
        cmd.issue = 1'b1;
        if (stat.last_tap) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // wait for the last product to land, then for room in the result register
        if (!stat.pipe_busy && stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/fir_rb_dp.sv =====
// fir_rb_dp: history and coefficient memories, tap-count register, ring pointers,
// MAC pipeline, rounding/saturation and the result register. Depends on fir_rb_pkg.
module fir_rb_dp #(
  parameter int unsigned MAX_TAPS = fir_rb_pkg::MAX_TAPS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  fir_rb_pkg::fir_cmd_t                   cmd,
  output fir_rb_pkg::fir_stat_t                  stat,
  input  logic                                   cfg_wr,
  input  logic [fir_rb_pkg::TAPS_W-1:0]          cfg_data,
  input  logic signed [fir_rb_pkg::SAMPLE_W-1:0] sample_in,
  input  logic [fir_rb_pkg::COEF_IDX_W-1:0]      coef_index,
  input  logic signed [fir_rb_pkg::SAMPLE_W-1:0] coef_value,
  input  logic                                   out_ready,
  output logic                                   out_valid,
  output logic signed [fir_rb_pkg::SAMPLE_W-1:0] filtered,
  output logic                                   saturated
);
  import fir_rb_pkg::*;

  localparam int unsigned ADDR_W  = $clog2(MAX_TAPS);
  localparam int unsigned CNT_W   = $clog2(MAX_TAPS + 1);
  localparam int unsigned SHIFT_W = ACC_W - FRAC_W;
  localparam logic [CNT_W-1:0] ONE = CNT_W'(1);
  localparam logic [ADDR_W-1:0] ADDR_ONE = ADDR_W'(1);
  localparam logic [CNT_W-1:0] TAPS_RESET =
    CNT_W'((TAPS_RST > MAX_TAPS) ? MAX_TAPS : TAPS_RST);
  localparam logic signed [SHIFT_W-1:0] OUT_MAX = SHIFT_W'(32767);
  localparam logic signed [SHIFT_W-1:0] OUT_MIN = SHIFT_W'(-32768);
  localparam logic signed [ACC_W-1:0]   HALF_LSB = ACC_W'(1 << (FRAC_W - 1));

  logic signed [SAMPLE_W-1:0] hist_mem [MAX_TAPS];
  logic signed [SAMPLE_W-1:0] coef_mem [MAX_TAPS];
  logic [MAX_TAPS-1:0]        hist_vld;
  logic [MAX_TAPS-1:0]        coef_vld;

  logic [CNT_W-1:0]  num_taps;
  logic [CNT_W-1:0]  taps_hold;
  logic [CNT_W-1:0]  last_k;
  logic [ADDR_W-1:0] wr_pos;
  logic [ADDR_W-1:0] pos_eff;
  logic [ADDR_W-1:0] pos_adv;
  logic [ADDR_W-1:0] rd_ptr;
  logic [ADDR_W-1:0] ring_top;
  logic [CNT_W-1:0]  k;

  logic [ADDR_W-1:0] coef_addr;
  logic              coef_ok;

  logic                       rd_v;
  logic                       mul_v;
  logic signed [SAMPLE_W-1:0] hist_q;
  logic signed [SAMPLE_W-1:0] coef_q;
  logic                       hist_q_vld;
  logic                       coef_q_vld;
  logic signed [SAMPLE_W-1:0] hist_op;
  logic signed [SAMPLE_W-1:0] coef_op;
  logic signed [PROD_W-1:0]   prod;
  logic signed [ACC_W-1:0]    acc;

  logic signed [ACC_W-1:0]    biased;
  logic signed [SHIFT_W-1:0]  shifted;
  logic                       sat_hi;
  logic                       sat_lo;

  // tap count: zero is held at one, anything above the store depth at the depth
  always_comb begin
    if (cfg_data == '0) begin
      taps_hold = ONE;
    end else if (int'(cfg_data) > int'(MAX_TAPS)) begin
      taps_hold = CNT_W'(MAX_TAPS);
    end else begin
      taps_hold = CNT_W'(cfg_data);
    end
  end

  assign last_k   = num_taps - ONE;
  assign ring_top = last_k[ADDR_W-1:0];
  assign pos_eff  = (CNT_W'(wr_pos) >= num_taps) ? '0 : wr_pos;
  assign pos_adv  = (CNT_W'(pos_eff) + ONE == num_taps) ? '0 : pos_eff + ADDR_ONE;

  assign coef_addr = ADDR_W'(coef_index);
  assign coef_ok   = int'(coef_index) < int'(MAX_TAPS);

  always_ff @(posedge clk) begin
    if (rst) begin
      num_taps <= TAPS_RESET;
      wr_pos   <= '0;
      hist_vld <= '0;
    end else if (cfg_wr) begin
      num_taps <= taps_hold;
      wr_pos   <= '0;
      hist_vld <= '0;
    end else if (cmd.take_sample) begin
      wr_pos           <= pos_adv;
      hist_vld[pos_eff] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_vld <= '0;
    end else if (cmd.take_coef && coef_ok) begin
      coef_vld[coef_addr] <= 1'b1;
    end
  end

  // memory writes
  always_ff @(posedge clk) begin
    if (cmd.take_sample) begin
      hist_mem[pos_eff] <= sample_in;
    end
    if (cmd.take_coef && coef_ok) begin
      coef_mem[coef_addr] <= coef_value;
    end
  end

  // tap walk: k counts up through the coefficients, rd_ptr walks the ring backward
  always_ff @(posedge clk) begin
    if (cmd.take_sample) begin
      k      <= '0;
      rd_ptr <= pos_eff;
    end else if (cmd.issue) begin
      k      <= k + ONE;
      rd_ptr <= (rd_ptr == '0) ? ring_top : rd_ptr - ADDR_ONE;
    end
  end

  // registered memory reads
  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      hist_q     <= hist_mem[rd_ptr];
      coef_q     <= coef_mem[k[ADDR_W-1:0]];
      hist_q_vld <= hist_vld[rd_ptr];
      coef_q_vld <= coef_vld[k[ADDR_W-1:0]];
    end
  end

  // entries never written since clear read as zero
  assign hist_op = hist_q_vld ? hist_q : '0;
  assign coef_op = coef_q_vld ? coef_q : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v  <= 1'b0;
      mul_v <= 1'b0;
    end else begin
      rd_v  <= cmd.issue;
      mul_v <= rd_v;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_v) begin
      prod <= coef_op * hist_op;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_sample) begin
      acc <= '0;
    end else if (mul_v) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  // round half up, then clip to q1.15
  assign biased  = acc + HALF_LSB;
  assign shifted = biased[ACC_W-1:FRAC_W];
  assign sat_hi  = shifted > OUT_MAX;
  assign sat_lo  = shifted < OUT_MIN;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      saturated <= sat_hi | sat_lo;
      if (sat_hi) begin
        filtered <= OUT_MAX[SAMPLE_W-1:0];
      end else if (sat_lo) begin
        filtered <= OUT_MIN[SAMPLE_W-1:0];
      end else begin
        filtered <= shifted[SAMPLE_W-1:0];
      end
    end
  end

  assign stat.last_tap  = (k == last_k);
  assign stat.pipe_busy = rd_v | mul_v;
  assign stat.out_free  = !out_valid || out_ready;

endmodule

// ===== sv/fir_filter_ring_buffer.sv =====
// fir_filter_ring_buffer: top level, joins controller, datapath and the channels.
// Depends on fir_rb_pkg, fir_rb_if, fir_rb_ctrl and fir_rb_dp.

// Direct-form FIR filter over a ring history of num_taps Q1.15 samples, with a
// 40-bit accumulator and a rounded, saturated Q1.15 result. A sample beat
// holds off other beats while the single shared multiply-accumulate steps
// one tap per cycle through the history and coefficient memories for all
// num_taps taps and the read/multiply/add pipeline drains into the result
// register; a coefficient beat is written without leaving idle and gives no
// result. The result register lets the next beat be taken while a result
// waits. Writing num_taps clears the history and write position at once
// (per-entry valid bits, no clearing pass); coefficients survive it.
module fir_filter_ring_buffer #(
  parameter int unsigned MAX_TAPS = fir_rb_pkg::MAX_TAPS_DEF
) (
  input logic          clk,
  input logic          rst,
  fir_rb_in_if.sink    item,
  fir_rb_out_if.source result,
  fir_rb_cfg_if.sink   cfg
);
  import fir_rb_pkg::*;

  fir_cmd_t  cmd;
  fir_stat_t stat;

  assign cfg.ready = 1'b1;

  fir_rb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_mode  (item.mode),
    .in_ready (item.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  fir_rb_dp #(
    .MAX_TAPS (MAX_TAPS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .cfg_wr     (cfg.valid & cfg.ready),
    .cfg_data   (cfg.data),
    .sample_in  (item.sample_in),
    .coef_index (item.coef_index),
    .coef_value (item.coef_value),
    .out_ready  (result.ready),
    .out_valid  (result.valid),
    .filtered   (result.filtered),
    .saturated  (result.saturated)
  );

  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!result.valid || result.ready))
    else $error("result register loaded while a beat was still waiting");

  // the sum is taken only after the last product has been added
  a_drained: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !stat.pipe_busy)
    else $error("result loaded with products still in flight");

  // a sample beat holds off the next beat while its taps are walked
  a_busy_after_sample: assert property (@(posedge clk) disable iff (rst)
    (item.valid && item.ready && item.mode == MODE_SAMPLE) |=> !item.ready)
    else $error("input taken again right after a sample beat");

endmodule

// ===== tb/fir_filter_ring_buffer_test.sv =====
// fir_filter_ring_buffer_test: self-checking bench for the ring-buffer fir filter.
// Directed and random beats run with stalls on both channels and are checked against
// a bit-true filter model kept in the bench. Depends on fir_rb_pkg, fir_rb_if, the RTL.
module fir_filter_ring_buffer_test;
  timeunit 1ns;
  timeprecision 1ps;
  import fir_rb_pkg::*;

  localparam int unsigned TAPS_MAX    = MAX_TAPS_DEF;
  localparam int unsigned SETTLE_CYC  = TAPS_MAX + 8;
  localparam int unsigned STALL_LIMIT = 4000;

  localparam logic signed [SAMPLE_W-1:0] Q15_MAX  = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] Q15_MIN  = 16'sh8000;
  localparam logic signed [ACC_W-1:0]    HALF_LSB = ACC_W'(1 <<< (FRAC_W - 1));

  typedef struct {
    logic [MODE_W-1:0]          mode;
    logic signed [SAMPLE_W-1:0] sample;
    logic [COEF_IDX_W-1:0]      idx;
    logic signed [SAMPLE_W-1:0] coef;
  } fir_item_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] filtered;
    logic                       saturated;
  } fir_out_t;

  logic clk;
  logic rst;

  fir_rb_in_if  in_ch ();
  fir_rb_out_if out_ch ();
  fir_rb_cfg_if cfg_ch ();

  fir_filter_ring_buffer i_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (in_ch),
    .result (out_ch),
    .cfg    (cfg_ch)
  );

  // filter model state
  logic signed [SAMPLE_W-1:0] ring [TAPS_MAX];
  logic signed [SAMPLE_W-1:0] coef_mem [TAPS_MAX];
  int unsigned ring_pos;
  int unsigned taps_in_use;

  fir_item_t   item_q[$];
  fir_out_t    filter_out_q[$];
  int unsigned items_queued;
  int unsigned items_taken;
  int unsigned errors;
  int unsigned src_idle_pct;
  int unsigned sink_stall_pct;
  int unsigned quiet_cycles;
  logic        item_taken;

  function automatic int unsigned clamp_taps(input logic [TAPS_W-1:0] v);
    if (v == 0) return 1;
    if (v > TAPS_MAX) return TAPS_MAX;
    return v;
  endfunction

  function automatic void clear_ring();
    foreach (ring[i]) ring[i] = '0;
    ring_pos = 0;
  endfunction

  function automatic fir_out_t filter_sample(input logic signed [SAMPLE_W-1:0] s);
    logic signed [ACC_W-1:0]  acc;
    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0]  rounded;
    int unsigned              rd;
    fir_out_t                 res;
    if (ring_pos >= taps_in_use) ring_pos = 0;
    ring[ring_pos] = s;
    rd = ring_pos;
    acc = '0;
    // walk backward from the newest sample, wrapping at the ring length
    for (int unsigned k = 0; k < taps_in_use; k++) begin
      prod = coef_mem[k] * ring[rd];
      acc += prod;
      rd = (rd == 0) ? taps_in_use - 1 : rd - 1;
    end
    ring_pos = (ring_pos + 1) % taps_in_use;
    // add half an lsb then floor shift: ties go toward plus infinity
    rounded = (acc + HALF_LSB) >>> FRAC_W;
    res.saturated = 1'b0;
    if (rounded > Q15_MAX) begin
      res.filtered  = Q15_MAX;
      res.saturated = 1'b1;
    end else if (rounded < Q15_MIN) begin
      res.filtered  = Q15_MIN;
      res.saturated = 1'b1;
    end else begin
      res.filtered = rounded[SAMPLE_W-1:0];
    end
    return res;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_q15();
    case ($urandom_range(9))
      0:       return Q15_MAX;
      1:       return Q15_MIN;
      2:       return SAMPLE_W'($urandom_range(255)) - 16'sd128;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic fir_item_t random_item(input int unsigned taps);
    fir_item_t it;
    it.mode   = ($urandom_range(99) < 20) ? MODE_COEF : MODE_SAMPLE;
    it.sample = pick_q15();
    // mostly slots inside the active taps, some anywhere in the store
    it.idx    = ($urandom_range(3) == 0) ? COEF_IDX_W'($urandom)
                                         : COEF_IDX_W'($urandom_range(taps - 1));
    it.coef   = pick_q15();
    return it;
  endfunction

  task automatic push_item(input fir_item_t it);
    item_q.push_back(it);
    items_queued++;
  endtask

  task automatic push_sample(input logic signed [SAMPLE_W-1:0] s);
    fir_item_t it;
    it = random_item(TAPS_MAX);
    it.mode   = MODE_SAMPLE;
    it.sample = s;
    push_item(it);
  endtask

  task automatic push_coef(input logic [COEF_IDX_W-1:0] idx,
                           input logic signed [SAMPLE_W-1:0] v);
    fir_item_t it;
    it = random_item(TAPS_MAX);
    it.mode = MODE_COEF;
    it.idx  = idx;
    it.coef = v;
    push_item(it);
  endtask

  // hold off until every beat is in and every result is out, then let the block settle
  task automatic wait_idle();
    while (items_taken != items_queued || filter_out_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_taps(input logic [TAPS_W-1:0] v);
    @(negedge clk);
    cfg_ch.data  <= v;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    taps_in_use = clamp_taps(v);
    clear_ring();
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // input driver, also drives the result channel's ready
  always @(negedge clk) begin
    fir_item_t nxt;
    if (!rst) begin
      if (!in_ch.valid || item_taken) begin
        if (item_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          nxt = item_q.pop_front();
          in_ch.valid      <= 1'b1;
          in_ch.mode       <= nxt.mode;
          in_ch.sample_in  <= nxt.sample;
          in_ch.coef_index <= nxt.idx;
          in_ch.coef_value <= nxt.coef;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
      out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // input monitor: runs the model on every accepted beat
  always @(posedge clk) begin
    item_taken <= !rst && in_ch.valid && in_ch.ready;
    if (!rst && in_ch.valid && in_ch.ready) begin
      items_taken++;
      if (in_ch.mode == MODE_COEF) begin
        if (in_ch.coef_index < TAPS_MAX) coef_mem[in_ch.coef_index] = in_ch.coef_value;
      end else begin
        filter_out_q.push_back(filter_sample(in_ch.sample_in));
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    fir_out_t exp_out;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (filter_out_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, expected none, got filtered %0d saturated %0b",
                 $time, out_ch.filtered, out_ch.saturated);
      end else begin
        exp_out = filter_out_q.pop_front();
        if (out_ch.filtered !== exp_out.filtered) begin
          errors++;
          $display("%0t: filtered mismatch, expected %0d, got %0d",
                   $time, exp_out.filtered, out_ch.filtered);
        end
        if (out_ch.saturated !== exp_out.saturated) begin
          errors++;
          $display("%0t: saturated mismatch, expected %0b, got %0b",
                   $time, exp_out.saturated, out_ch.saturated);
        end
      end
    end
  end

  // watchdog on cycles with no beat on any channel
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    logic [TAPS_W-1:0] tap_plan [11];
    int unsigned       n_items;
    tap_plan = '{6'd1, 6'd32, 6'd5, 6'd5, 6'd0, 6'd63, 6'd33, 6'd17, 6'd2, 6'd31, 6'd8};
    rst              = 1'b1;
    in_ch.valid      = 1'b0;
    in_ch.mode       = MODE_SAMPLE;
    in_ch.sample_in  = '0;
    in_ch.coef_index = '0;
    in_ch.coef_value = '0;
    out_ch.ready     = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.data      = '0;
    item_taken       = 1'b0;
    items_queued     = 0;
    items_taken      = 0;
    errors           = 0;
    quiet_cycles     = 0;
    src_idle_pct     = 15;
    sink_stall_pct   = 52;
    foreach (coef_mem[i]) coef_mem[i] = '0;
    clear_ring();
    taps_in_use = clamp_taps(TAPS_W'(TAPS_RST));
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: extremes, both saturation sides, rounding ties, far slot
    push_sample(Q15_MAX);
    push_sample(Q15_MIN);
    push_coef(COEF_IDX_W'(0), Q15_MIN);
    push_coef(COEF_IDX_W'(TAPS_MAX - 1), Q15_MAX);
    push_sample(Q15_MIN);
    push_sample(Q15_MAX);
    push_coef(COEF_IDX_W'(1), Q15_MIN);
    push_sample(Q15_MAX);
    push_coef(COEF_IDX_W'(0), 16'sd1);
    push_coef(COEF_IDX_W'(1), 16'sd0);
    push_sample(16'sd16384);
    push_sample(-16'sd16384);
    push_sample(-16'sd1);
    push_coef(COEF_IDX_W'(0), 16'sd0);
    push_sample(16'sd0);
    wait_idle();

    // one tap setting per phase; a repeated setting checks that the write clears history
    foreach (tap_plan[p]) begin
      if (p < 4) begin
        src_idle_pct   = 15;
        sink_stall_pct = 52;
      end else if (p < 8) begin
        src_idle_pct   = 52;
        sink_stall_pct = 15;
      end else begin
        src_idle_pct   = 0;
        sink_stall_pct = 0;
      end
      write_taps(tap_plan[p]);
      n_items = 107 + $urandom_range(20);
      repeat (n_items) push_item(random_item(taps_in_use));
      wait_idle();
    end

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
